FILE: hw/rtl/zolr_pkg.sv
// ============================================================================
// zolr_pkg - shared types and codes for the ordered list reorder block
// Operation codes, status codes, sequencer states and the result bundle.
// ============================================================================
`default_nettype none

package zolr_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int ID_W     = 16;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FWD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BWD    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD       = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/zolr_mem.sv
// ============================================================================
// zolr_mem - list entry storage
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module zolr_mem #(
  parameter int DEPTH  = zolr_pkg::MAX_ENTRIES_DEF,
  parameter int DATA_W = zolr_pkg::ID_W
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [DATA_W-1:0]         wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/zolr_seq.sv
// ============================================================================
// zolr_seq - list sequencer
// Scans the store one entry a cycle for the first match, then walks the
// shift pass through the separate read and write ports and drops the item in place.
// ============================================================================
`default_nettype none

module zolr_seq #(
  parameter int MAX_ENTRIES = zolr_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [zolr_pkg::MODE_W-1:0]         mode,
  input  wire logic [zolr_pkg::ID_W-1:0]           item_id,
  output logic                                     busy,
  output logic                                     mem_we,
  output logic      [$clog2(MAX_ENTRIES)-1:0]      mem_waddr,
  output logic      [zolr_pkg::ID_W-1:0]           mem_wdata,
  output logic                                     mem_re,
  output logic      [$clog2(MAX_ENTRIES)-1:0]      mem_raddr,
  input  wire logic [zolr_pkg::ID_W-1:0]           mem_rdata,
  output logic                                     done,
  output zolr_pkg::result_t                        res
);

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int LEN_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W    = zolr_pkg::ID_W;
  localparam int MODE_W  = zolr_pkg::MODE_W;
  localparam int POS_W   = zolr_pkg::POS_W;
  localparam int COUNT_W = zolr_pkg::COUNT_W;

  zolr_pkg::state_t state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LEN_W-1:0]  scan_r, scan_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              wpend_r, wpend_nxt;

  logic [LEN_W-1:0]  k_len;
  logic              hit;

  assign k_len = LEN_W'(cmp_idx_r);
  assign hit   = cmp_v_r && (mem_rdata == id_r);
  assign busy  = (state_r != zolr_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zolr_pkg::S_IDLE;
      len_r   <= '0;
      cmp_v_r <= 1'b0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cmp_v_r <= cmp_v_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    id_r      <= id_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    dir_up_r  <= dir_up_nxt;
    rem_r     <= rem_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    mode_nxt    = mode_r;
    id_nxt      = id_r;
    scan_nxt    = scan_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    dir_up_nxt  = dir_up_r;
    rem_nxt     = rem_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    wpend_nxt   = wpend_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    done        = 1'b0;
    res         = '0;

    unique case (state_r)
      zolr_pkg::S_IDLE: begin
        if (start) begin
          case (mode)
            zolr_pkg::MODE_APPEND: begin
              done = 1'b1;
              if (len_r == LEN_W'(MAX_ENTRIES)) begin
                res.status      = zolr_pkg::STATUS_FULL;
                res.entry_count = COUNT_W'(len_r);
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = len_r[IDX_W-1:0];
                mem_wdata       = item_id;
                len_nxt         = len_r + 1'b1;
                res.status      = zolr_pkg::STATUS_OK;
                res.position    = POS_W'(len_r);
                res.entry_count = COUNT_W'(len_nxt);
              end
            end
            zolr_pkg::MODE_CLEAR: begin
              done    = 1'b1;
              len_nxt = '0;
            end
            zolr_pkg::MODE_FRONT, zolr_pkg::MODE_BACK,
            zolr_pkg::MODE_FWD, zolr_pkg::MODE_BWD: begin
              mode_nxt  = mode;
              id_nxt    = item_id;
              scan_nxt  = '0;
              cmp_v_nxt = 1'b0;
              state_nxt = zolr_pkg::S_SCAN;
            end
            default: begin
              // unused codes: report current length, no change
              done            = 1'b1;
              res.entry_count = COUNT_W'(len_r);
            end
          endcase
        end
      end

      zolr_pkg::S_SCAN: begin
        if (hit) begin
          // first match at cmp_idx_r: set up the shift pass
          cmp_v_nxt  = 1'b0;
          wr_ptr_nxt = cmp_idx_r;
          wpend_nxt  = 1'b0;
          state_nxt  = zolr_pkg::S_SHIFT;
          case (mode_r)
            zolr_pkg::MODE_FRONT: begin
              dir_up_nxt = 1'b1;
              rem_nxt    = IDX_W'(len_r - k_len - LEN_W'(1));
            end
            zolr_pkg::MODE_BACK: begin
              dir_up_nxt = 1'b0;
              rem_nxt    = cmp_idx_r;
            end
            zolr_pkg::MODE_FWD: begin
              dir_up_nxt = 1'b1;
              rem_nxt    = ((k_len + LEN_W'(1)) < len_r) ? IDX_W'(1) : '0;
            end
            default: begin
              dir_up_nxt = 1'b0;
              rem_nxt    = (cmp_idx_r != '0) ? IDX_W'(1) : '0;
            end
          endcase
          rd_ptr_nxt = dir_up_nxt ? cmp_idx_r + 1'b1 : cmp_idx_r - 1'b1;
        end else if (scan_r < len_r) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_r[IDX_W-1:0];
          cmp_idx_nxt = scan_r[IDX_W-1:0];
          cmp_v_nxt   = 1'b1;
          scan_nxt    = scan_r + 1'b1;
        end else begin
          // every entry compared, no match
          cmp_v_nxt       = 1'b0;
          done            = 1'b1;
          res.status      = zolr_pkg::STATUS_NOT_FOUND;
          res.entry_count = COUNT_W'(len_r);
          state_nxt       = zolr_pkg::S_IDLE;
        end
      end

      zolr_pkg::S_SHIFT: begin
        if (wpend_r) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r;
          mem_wdata  = mem_rdata;
          wr_ptr_nxt = dir_up_r ? wr_ptr_r + 1'b1 : wr_ptr_r - 1'b1;
        end
        if (rem_r != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r;
          rd_ptr_nxt = dir_up_r ? rd_ptr_r + 1'b1 : rd_ptr_r - 1'b1;
          rem_nxt    = rem_r - 1'b1;
          wpend_nxt  = 1'b1;
        end else begin
          wpend_nxt = 1'b0;
        end
        if ((rem_r == '0) && !wpend_r) begin
          // gap is open at wr_ptr_r: drop the item there
          mem_we          = 1'b1;
          mem_waddr       = wr_ptr_r;
          mem_wdata       = id_r;
          done            = 1'b1;
          res.status      = zolr_pkg::STATUS_OK;
          res.position    = POS_W'(wr_ptr_r);
          res.entry_count = COUNT_W'(len_r);
          state_nxt       = zolr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = zolr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/z_order_list_reorder_top.sv
// ============================================================================
// z_order_list_reorder_top - ordered list with move-to-front and swaps
// Keeps up to MAX_ENTRIES 16-bit identifiers (index 0 = back) and applies
// append, move to front/back, one-place swaps and clear.
// ============================================================================
// Using the block: an item is taken when start is high and busy is low, and
// it always produces exactly one result, shown for a single cycle with
// out_valid high in the cycle after the sequencer finishes. There is no way to
// hold a result off, so the receiver must capture it on that cycle. Append,
// clear and the unused codes (six, seven) finish in the accept cycle itself:
// busy never rises and a new item can follow on the very next cycle. The
// move codes (to front, to back, forward, backward) raise busy while a
// sequencer walks the entry memory, which has one read and one write port:
// the search reads one entry per cycle from index 0 up to the first match
// (or through the whole list when nothing matches), then the shift pass
// moves one entry per cycle and finally writes the item into the gap. The
// longest busy stretch is the front entry of a full list moved to the back
// (longest search and longest shift). Only the first (lowest index) match
// of a duplicated identifier is moved. Reset clears the list length;
// the entry memory itself is not cleared and needs no clearing pass.
// ============================================================================
`default_nettype none

module z_order_list_reorder_top #(
  parameter int MAX_ENTRIES = zolr_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [zolr_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [zolr_pkg::ID_W-1:0]         in_item_id,
  output logic                                   out_valid,
  output logic      [zolr_pkg::STATUS_W-1:0]     out_status,
  output logic      [zolr_pkg::POS_W-1:0]        out_position,
  output logic      [zolr_pkg::COUNT_W-1:0]      out_entry_count
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  // memory port between sequencer and store
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [zolr_pkg::ID_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_raddr;
  logic [zolr_pkg::ID_W-1:0] mem_rdata;

  logic                      done;
  zolr_pkg::result_t         res;

  // result register: one-cycle strobe plus payload
  logic                      out_valid_r;
  zolr_pkg::result_t         res_r;

  zolr_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (in_mode),
    .item_id   (in_item_id),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .done      (done),
    .res       (res)
  );

  zolr_mem #(
    .DEPTH  (MAX_ENTRIES),
    .DATA_W (zolr_pkg::ID_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  // payload needs no reset; only read under out_valid
  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_position    = res_r.position;
  assign out_entry_count = res_r.entry_count;

endmodule

`default_nettype wire

FILE: hw/rtl/zolr_chk.sv
// ============================================================================
// zolr_chk - port-level checks for the ordered list reorder block
// Watches the top-level ports only; attached by bind.
// ============================================================================
`default_nettype none

module zolr_chk #(
  parameter int MAX_ENTRIES = zolr_pkg::MAX_ENTRIES_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [zolr_pkg::MODE_W-1:0]    in_mode,
  input wire logic                           out_valid,
  input wire logic [zolr_pkg::STATUS_W-1:0]  out_status,
  input wire logic [zolr_pkg::POS_W-1:0]     out_position,
  input wire logic [zolr_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int COUNT_W = zolr_pkg::COUNT_W;

  logic take;
  logic take_move;

  assign take      = start && !busy;
  assign take_move = take && ((in_mode == zolr_pkg::MODE_FRONT) ||
                              (in_mode == zolr_pkg::MODE_BACK)  ||
                              (in_mode == zolr_pkg::MODE_FWD)   ||
                              (in_mode == zolr_pkg::MODE_BWD));

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != zolr_pkg::STATUS_BAD))
    else $error("reserved status code on result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= COUNT_W'(MAX_ENTRIES)))
    else $error("entry count beyond list capacity");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_mode == zolr_pkg::MODE_CLEAR)) |=>
      (out_valid && (out_entry_count == '0) && (out_position == '0)))
    else $error("clear did not report an empty list next cycle");

  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take_move |=> (busy && !out_valid))
    else $error("move item did not start the sequencer");

  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != zolr_pkg::STATUS_OK)) |-> (out_position == '0))
    else $error("failed item reported a nonzero position");

endmodule

bind z_order_list_reorder_top zolr_chk #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_zolr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count)
);

`default_nettype wire

FILE: verif/zolr_result_checker.sv
// ============================================================================
// zolr_result_checker - result predictor and scoreboard for the reorder list
// Watches accepted items and result strobes, keeps its own copy of the list,
// and compares each result field by field with the oldest prediction.
// ============================================================================
`default_nettype none

module zolr_result_checker
  import zolr_pkg::*;
#(
  parameter int LIST_DEPTH = MAX_ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [ID_W-1:0]     in_item_id,
  input  wire logic                out_valid,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic [POS_W-1:0]    out_position,
  input  wire logic [COUNT_W-1:0]  out_entry_count,
  output int                       fail_count,
  output int                       outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [ID_W-1:0] entries [LIST_DEPTH];
  int              fill;
  result_t         pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    fill        = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Applies one item to the shadow list and returns the result it causes.
  task automatic apply_op(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] id,
                          output result_t res);
    int              hit;
    logic [ID_W-1:0] held;
    hit          = -1;
    res.status   = STATUS_OK;
    res.position = '0;
    case (op)
      MODE_APPEND: begin
        if (fill >= LIST_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          entries[fill] = id;
          res.position  = POS_W'(fill);
          fill++;
        end
      end
      MODE_CLEAR: begin
        fill = 0;
      end
      MODE_FRONT, MODE_BACK, MODE_FWD, MODE_BWD: begin
        // first match wins: lowest index
        for (int i = 0; i < fill; i++) begin
          if (hit < 0 && entries[i] == id) hit = i;
        end
        if (hit < 0) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          held = entries[hit];
          case (op)
            MODE_FRONT: begin
              for (int i = hit; i < fill - 1; i++) entries[i] = entries[i + 1];
              entries[fill - 1] = held;
              res.position      = POS_W'(fill - 1);
            end
            MODE_BACK: begin
              for (int i = hit; i > 0; i--) entries[i] = entries[i - 1];
              entries[0] = held;
            end
            MODE_FWD: begin
              res.position = POS_W'(hit);
              if (hit + 1 < fill) begin
                entries[hit]     = entries[hit + 1];
                entries[hit + 1] = held;
                res.position     = POS_W'(hit + 1);
              end
            end
            default: begin
              res.position = POS_W'(hit);
              if (hit > 0) begin
                entries[hit]     = entries[hit - 1];
                entries[hit - 1] = held;
                res.position     = POS_W'(hit - 1);
              end
            end
          endcase
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
    res.entry_count = COUNT_W'(fill);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t made;
    if (!rst_n) begin
      fill = 0;
      pending_results.delete();
    end else begin
      // results first: a result always belongs to an earlier item
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d pos %0d count %0d",
                                    out_status, out_position, out_entry_count));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
          if (out_position !== want.position)
            report_mismatch($sformatf("position got %0d expected %0d",
                                      out_position, want.position));
          if (out_entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_entry_count, want.entry_count));
        end
      end
      if (start && !busy) begin
        apply_op(in_mode, in_item_id, made);
        pending_results.push_back(made);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

FILE: verif/z_order_list_reorder_top_test.sv
// ============================================================================
// z_order_list_reorder_top_test - testbench top for the reorder list block
// Drives directed and random list operations with random sender gaps and
// leaves prediction and comparison to the result checker beside the block.
// ============================================================================
`default_nettype none

module z_order_list_reorder_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import zolr_pkg::*;

  localparam int LIST_DEPTH = MAX_ENTRIES_DEF;

  // the two unused operation codes, which the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam int RAND_ITEMS  = 850;
  localparam int QUIET_ITEMS = 100;  // tail of the run without sender gaps
  localparam int POOL_SIZE   = 8;
  localparam int DRAIN_WAIT  = 2 * LIST_DEPTH + 8;  // worst busy stretch plus margin

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   in_mode    = MODE_APPEND;
  logic [ID_W-1:0]     in_item_id = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;
  logic [COUNT_W-1:0]  out_entry_count;
  int                  fail_count;
  int                  outstanding;

  // identifiers the random part draws from, so moves mostly find a match
  logic [ID_W-1:0]     id_pool [POOL_SIZE];

  always #4 clk = ~clk;

  z_order_list_reorder_top #(
    .MAX_ENTRIES (LIST_DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_item_id      (in_item_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  zolr_result_checker #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_item_id      (in_item_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Presents one item and returns at the edge that accepts it. Start is left
  // high so a back-to-back item needs no second assignment in the same step.
  task automatic send_item(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] id);
    start      <= 1'b1;
    in_mode    <= op;
    in_item_id <= id;
    do @(posedge clk); while (busy);
  endtask

  // Drops start and holds off until the checker has seen every result.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);  // let the last accept land in the checker's count
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));
    // keep the all-zero and all-one identifiers in play now and then
    if ($urandom_range(0, 3) == 0) id_pool[0] = '0;
    if ($urandom_range(0, 3) == 0) id_pool[1] = '1;
  endtask

  initial begin : stimulus
    int                pick;
    logic [MODE_W-1:0] op;
    logic [ID_W-1:0]   id;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    send_item(MODE_FRONT, 16'h0000);     // move on an empty list: not found
    send_item(MODE_APPEND, 16'h0000);
    send_item(MODE_APPEND, 16'hFFFF);
    send_item(MODE_APPEND, 16'h1234);
    send_item(MODE_APPEND, 16'h0000);    // duplicate: only the lower-index copy moves
    send_item(MODE_FRONT, 16'h0000);     // first match goes to the front
    send_item(MODE_BACK, 16'h1234);
    send_item(MODE_FWD, 16'h0000);       // both copies of 0 at the front: equal swap
    send_item(MODE_FWD, 16'hFFFF);
    send_item(MODE_BWD, 16'h1234);       // already at the back: stays put
    send_item(MODE_BWD, 16'hFFFF);
    send_item(MODE_UNUSED_LO, 16'hFFFF); // ignored codes report current count
    send_item(MODE_UNUSED_HI, 16'h0000);
    send_item(MODE_BWD, 16'hABCD);       // not found on a non-empty list
    send_item(MODE_CLEAR, 16'hFFFF);
    // fill to the limit, then one append too many
    for (int i = 0; i <= LIST_DEPTH; i++) send_item(MODE_APPEND, ID_W'(i * 4099));
    send_item(MODE_FRONT, 16'h0000);     // back entry of a full list: longest shift
    send_item(MODE_FWD, ID_W'(3 * 4099));
    send_item(MODE_BACK, 16'h0000);      // front entry to the back: longest shift
    send_item(MODE_CLEAR, 16'h0000);

    // ---- random part ----
    refresh_pool();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      id   = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 35) op = MODE_APPEND;
      else if (pick < 50) op = MODE_FRONT;
      else if (pick < 64) op = MODE_BACK;
      else if (pick < 77) op = MODE_FWD;
      else if (pick < 90) op = MODE_BWD;
      else if (pick < 92) op = MODE_CLEAR;
      else if (pick < 95) begin
        op = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
        id = ID_W'($urandom_range(0, 16'hFFFF));
      end else begin
        // noise: a move on an identifier that is most likely absent
        op = MODE_W'(MODE_FRONT + $urandom_range(0, 3));
        id = ID_W'($urandom_range(0, 16'hFFFF));
      end
      send_item(op, id);
      if (op == MODE_CLEAR) refresh_pool();
      else if ($urandom_range(0, 19) == 0) id_pool[$urandom_range(0, POOL_SIZE - 1)] = id;

      if (n == RAND_ITEMS / 2) begin
        wait_drained();  // sender holds off until every result is back
      end else if (n < RAND_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end

    // ---- wind down ----
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/zolr_pkg.sv
hw/rtl/zolr_mem.sv
hw/rtl/zolr_seq.sv
hw/rtl/z_order_list_reorder_top.sv
hw/rtl/zolr_chk.sv
verif/zolr_result_checker.sv
verif/z_order_list_reorder_top_test.sv
